// ----- design/mrs_pkg.sv -----
// shared constants and types for the refuel-stop heap block
`default_nettype none
package mrs_pkg;
    localparam int HeapDepth = 1024;
    localparam int AddrW = $clog2(HeapDepth);
    localparam int CntW = $clog2(HeapDepth + 1);
    localparam int FuelW = 8;
    localparam int DistW = 20;
    localparam int TankW = 23;
    localparam int StopsW = 11;
    localparam logic [StopsW-1:0] StopsMax = '1;
    localparam logic [1:0] StReached = 2'd0;
    localparam logic [1:0] StUnreach = 2'd1;
    localparam logic [1:0] StOverflow = 2'd2;

    typedef struct packed {
        logic [DistW-1:0] segment_distance;
        logic [FuelW-1:0] stop_fuel;
        logic             last_segment;
    } item_t;

    typedef struct packed {
        logic [StopsW-1:0] stop_count;
        logic [1:0]        status;
    } result_t;
endpackage
`default_nettype wire

// ----- design/mrs_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module mrs_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- design/mrs_heap.sv -----
// max-heap sequencer over one ram port, one compare a step
`default_nettype none
module mrs_heap (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      clr,
    input  wire logic                      push,
    input  wire logic                      pop,
    input  wire logic [mrs_pkg::FuelW-1:0] push_val,
    output logic                           busy,
    output logic [mrs_pkg::FuelW-1:0]      top_val,
    output logic                           empty,
    output logic                           full
);
    import mrs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PU_RD = 4'd1;
    localparam logic [3:0] S_PU_CM = 4'd2;
    localparam logic [3:0] S_PO_T  = 4'd3;
    localparam logic [3:0] S_PO_TW = 4'd4;
    localparam logic [3:0] S_PO_L  = 4'd5;
    localparam logic [3:0] S_PO_LW = 4'd6;
    localparam logic [3:0] S_PO_C1 = 4'd7;
    localparam logic [3:0] S_PO_C2 = 4'd8;
    localparam logic [3:0] S_PO_CW = 4'd9;
    localparam logic [3:0] S_PO_CM = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [CntW-1:0]  idx_reg, idx_next;
    logic [CntW-1:0]  ch_reg, ch_next;
    logic [FuelW-1:0] val_reg, val_next;
    logic [FuelW-1:0] c1_reg, c1_next;
    logic [FuelW-1:0] top_reg, top_next;

    logic             we;
    logic [CntW-1:0]  addr;
    logic [FuelW-1:0] wdata, rdata;

    mrs_ram #(.Width(FuelW), .Depth(HeapDepth)) u_ram (
        .clk(clk), .we(we), .addr(addr[AddrW-1:0]), .wdata(wdata), .rdata(rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign empty = (count_reg == '0);
    assign full = (count_reg == CntW'(HeapDepth));
    assign top_val = top_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        ch_next = ch_reg;
        val_next = val_reg;
        c1_next = c1_reg;
        top_next = top_reg;
        we = 1'b0;
        addr = idx_reg;
        wdata = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (clr)
                begin
                    count_next = '0;
                end
                else if (push)
                begin
                    val_next = push_val;
                    idx_next = count_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_PU_RD;
                end
                else if (pop)
                begin
                    state_next = S_PO_T;
                end
            end
            S_PU_RD:
            begin
                if (idx_reg == '0)
                begin
                    we = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr = (idx_reg - 1'b1) >> 1;
                    state_next = S_PU_CM;
                end
            end
            S_PU_CM:
            begin
                // rdata holds parent
                if (rdata >= val_reg)
                begin
                    we = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    we = 1'b1;
                    wdata = rdata;
                    idx_next = (idx_reg - 1'b1) >> 1;
                    state_next = S_PU_RD;
                end
            end
            S_PO_T:
            begin
                addr = '0;
                state_next = S_PO_TW;
            end
            S_PO_TW:
            begin
                top_next = rdata;
                addr = count_reg - 1'b1;
                count_next = count_reg - 1'b1;
                state_next = S_PO_LW;
            end
            S_PO_LW:
            begin
                val_next = rdata;
                idx_next = '0;
                state_next = S_PO_L;
            end
            S_PO_L:
            begin
                // left child index check
                ch_next = {idx_reg[CntW-2:0], 1'b1};
                if ({idx_reg, 1'b1} >= {1'b0, count_reg})
                begin
                    we = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr = {idx_reg[CntW-2:0], 1'b1};
                    state_next = S_PO_C1;
                end
            end
            S_PO_C1:
            begin
                c1_next = rdata;
                if (ch_reg + 1'b1 < count_reg)
                begin
                    addr = ch_reg + 1'b1;
                    state_next = S_PO_C2;
                end
                else
                begin
                    state_next = S_PO_CM;
                end
            end
            S_PO_C2:
            begin
                if (rdata > c1_reg)
                begin
                    c1_next = rdata;
                    ch_next = ch_reg + 1'b1;
                end
                state_next = S_PO_CM;
            end
            S_PO_CM:
            begin
                if (c1_reg <= val_reg)
                begin
                    we = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    we = 1'b1;
                    wdata = c1_reg;
                    idx_next = ch_reg;
                    state_next = S_PO_L;
                end
            end
            S_PO_CW: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ch_reg <= ch_next;
        val_reg <= val_next;
        c1_reg <= c1_next;
        top_reg <= top_next;
    end
endmodule
`default_nettype wire

// ----- design/min_refuel_stops_greedy_heap.sv -----
// top level: trip sequencer around the fuel max-heap
//
//  channel  dir  fields
//  s_axis   in   tdata {stop_fuel, segment_distance}, tlast last_segment
//  m_axis   out  tdata {status, stop_count}
//  cfg      in   initial_fuel
//
// a segment steps through accept, subtract, check, then push or done; once the
// trip has failed, accept goes straight to done. each stop and each push waits
// on the heap, whose pace is set by the single ram port. reset is asynchronous;
// the heap ram needs no clearing. a held result waits in the output register
// and stalls the next item.
`default_nettype none
module min_refuel_stops_greedy_heap (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [19:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // segment_distance, stop_fuel
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // stop_count, status
);
    import mrs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_POPW = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_WAIT = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [19:0]       init_reg;
    item_t             item_reg;
    logic signed [TankW-1:0] fuel_reg, fuel_next;
    logic [StopsW-1:0] stops_reg, stops_next;
    logic              failed_reg, failed_next;
    logic              ovf_reg, ovf_next;
    logic              intrip_reg, intrip_next;
    result_t           res_reg, res_next;
    logic              ov_reg, ov_next;
    logic              h_push, h_pop, h_clr, h_busy, h_empty, h_full;
    logic [FuelW-1:0]  h_top;
    item_t             in_item;

    assign in_item.segment_distance = s_axis_tdata[19:0];
    assign in_item.stop_fuel = s_axis_tdata[27:20];
    assign in_item.last_segment = s_axis_tlast;

    mrs_heap u_heap (
        .clk(clk), .rst_n(rst_n), .clr(h_clr), .push(h_push), .pop(h_pop),
        .push_val(item_reg.stop_fuel), .busy(h_busy), .top_val(h_top),
        .empty(h_empty), .full(h_full)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {3'b0, res_reg.status, res_reg.stop_count};

    always_comb
    begin
        state_next = state_reg;
        fuel_next = fuel_reg;
        stops_next = stops_reg;
        failed_next = failed_reg;
        ovf_next = ovf_reg;
        intrip_next = intrip_reg;
        res_next = res_reg;
        ov_next = ov_reg && !m_axis_tready;
        h_push = 1'b0;
        h_pop = 1'b0;
        h_clr = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (!intrip_reg)
                    begin
                        fuel_next = TankW'(init_reg);
                        intrip_next = 1'b1;
                    end
                    state_next = failed_reg ? S_DONE : S_SUB;
                end
            end
            S_SUB:
            begin
                fuel_next = fuel_reg - TankW'(item_reg.segment_distance);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (fuel_reg >= 0)
                begin
                    state_next = item_reg.last_segment ? S_DONE : S_PUSH;
                end
                else if (h_empty)
                begin
                    failed_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    h_pop = 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                if (!h_busy)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                fuel_next = fuel_reg + TankW'(h_top);
                if (stops_reg != StopsMax)
                begin
                    stops_next = stops_reg + 1'b1;
                end
                state_next = S_CHK;
            end
            S_PUSH:
            begin
                if (h_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    h_push = 1'b1;
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!h_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (item_reg.last_segment)
                begin
                    ov_next = 1'b1;
                    if (ovf_reg)
                    begin
                        res_next = '{stop_count: stops_reg, status: StOverflow};
                    end
                    else if (failed_reg)
                    begin
                        res_next = '{stop_count: '0, status: StUnreach};
                    end
                    else
                    begin
                        res_next = '{stop_count: stops_reg, status: StReached};
                    end
                    h_clr = 1'b1;
                    fuel_next = '0;
                    stops_next = '0;
                    failed_next = 1'b0;
                    ovf_next = 1'b0;
                    intrip_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            init_reg <= '0;
            fuel_reg <= '0;
            stops_reg <= '0;
            failed_reg <= 1'b0;
            ovf_reg <= 1'b0;
            intrip_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                init_reg <= cfg_wdata;
            end
            fuel_reg <= fuel_next;
            stops_reg <= stops_next;
            failed_reg <= failed_next;
            ovf_reg <= ovf_next;
            intrip_reg <= intrip_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= in_item;
        end
    end
endmodule
`default_nettype wire

// ----- design/mrs_checker.sv -----
// port-level checks for the refuel-stop block
`default_nettype none
module mrs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    import mrs_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:11] <= StOverflow)
        else $error("bad status");
    a_unr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[12:11] == StUnreach |-> m_axis_tdata[10:0] == '0)
        else $error("unreachable with stops");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after transfer");
endmodule

bind min_refuel_stops_greedy_heap mrs_checker u_chk (.*);
`default_nettype wire
